[rtl/core/csv_pkg.sv]
// Shared types and constants for the command settings validator.
package csv_pkg;

    // ASCII characters recognized in a command.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_T     = 8'h54;

    // Digit lanes cover command positions 2 to 9.
    localparam int LANE_LO = 2;
    localparam int LANE_HI = 9;

    // Range limits.
    localparam logic [3:0] TRIG_MAX       = 4'd4;
    localparam logic [3:0] LINE_MIN       = 4'd1;
    localparam logic [3:0] LINE_MAX       = 4'd8;
    localparam logic [3:0] A_LINE         = 4'd8;
    localparam logic [3:0] A_COUNT        = 4'd1;
    localparam logic [6:0] D_RATE_MAX     = 7'd16;
    localparam logic [6:0] A_RATE_MAX     = 7'd13;
    localparam logic [9:0] DEPTH_MAX      = 10'd192;
    localparam logic [9:0] COMPARE_MAX    = 10'd330;

    // Error codes.
    localparam logic [4:0] ERR_NONE         = 5'd0;
    localparam logic [4:0] ERR_DA_SYNTAX    = 5'd1;
    localparam logic [4:0] ERR_CV_SYNTAX    = 5'd2;
    localparam logic [4:0] ERR_CT_SYNTAX    = 5'd3;
    localparam logic [4:0] ERR_C_FORM       = 5'd4;
    localparam logic [4:0] ERR_UNKNOWN      = 5'd5;
    localparam logic [4:0] ERR_D_TRIG       = 5'd6;
    localparam logic [4:0] ERR_D_LINE       = 5'd7;
    localparam logic [4:0] ERR_D_COUNT      = 5'd8;
    localparam logic [4:0] ERR_D_LINE_COUNT = 5'd9;
    localparam logic [4:0] ERR_D_RATE       = 5'd10;
    localparam logic [4:0] ERR_D_DEPTH      = 5'd11;
    localparam logic [4:0] ERR_A_TRIG       = 5'd12;
    localparam logic [4:0] ERR_A_LINE       = 5'd13;
    localparam logic [4:0] ERR_A_COUNT      = 5'd14;
    localparam logic [4:0] ERR_A_RATE       = 5'd15;
    localparam logic [4:0] ERR_A_DEPTH      = 5'd16;
    localparam logic [4:0] ERR_CV_RANGE     = 5'd17;
    localparam logic [4:0] ERR_LAST         = 5'd18;

    // Capture modes and pending orders.
    localparam logic       MODE_DIGITAL  = 1'b0;
    localparam logic       MODE_ANALOG   = 1'b1;
    localparam logic [1:0] ORDER_NONE    = 2'd0;
    localparam logic [1:0] ORDER_SAMPLE  = 2'd1;
    localparam logic [1:0] ORDER_VOLTAGE = 2'd2;

    // What one lane finds in its byte.
    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } t_lane;

    typedef t_lane [LANE_HI:LANE_LO] t_lanes;

    // Stored capture settings.
    typedef struct packed {
        logic        mode;
        logic [2:0]  trig_kind;
        logic [3:0]  trig_line;
        logic [3:0]  chan_count;
        logic [4:0]  rate;
        logic [7:0]  depth;
        logic [8:0]  compare;
        logic [13:0] timeout;
        logic [1:0]  order;
    } t_settings;

    // Outcome of checking one command.
    typedef struct packed {
        logic       accepted;
        logic [4:0] err;
        t_settings  next;
    } t_verdict;

endpackage

[rtl/core/csv_lane.sv]
// One digit lane: classifies a command byte and extracts its digit value.
module csv_lane (
    input  logic [7:0]     i_byte,
    output csv_pkg::t_lane o_lane
);
    import csv_pkg::*;

    assign o_lane.is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // For an ASCII digit the low nibble is already its value.
    assign o_lane.value    = i_byte[3:0];

endmodule

[rtl/core/csv_merge.sv]
// Merge stage: combines lane results into an error code and next settings.
module csv_merge (
    input  logic [7:0]         i_byte_1,
    input  logic [7:0]         i_byte_2,
    input  logic [7:0]         i_byte_6,
    input  logic [7:0]         i_byte_7,
    input  logic [7:0]         i_byte_10,
    input  csv_pkg::t_lanes    i_lanes,
    input  csv_pkg::t_settings i_cur,
    output csv_pkg::t_verdict  o_verdict
);
    import csv_pkg::*;

    logic        w_ok_2_9;
    logic        w_ok_3_5;
    logic        w_ok_3_6;
    logic        w_is_da;
    logic        w_is_c;
    logic        w_cv_form;
    logic        w_ct_form;
    logic [3:0]  w_d2, w_d3, w_d4, w_d5, w_d6, w_d7, w_d8, w_d9;
    logic [6:0]  w_rate;
    logic [9:0]  w_depth;
    logic [9:0]  w_cv_val;
    logic [13:0] w_ct_val;
    logic        w_count_ok;
    logic [4:0]  w_err;
    t_settings   w_next;

    assign w_d2 = i_lanes[2].value;
    assign w_d3 = i_lanes[3].value;
    assign w_d4 = i_lanes[4].value;
    assign w_d5 = i_lanes[5].value;
    assign w_d6 = i_lanes[6].value;
    assign w_d7 = i_lanes[7].value;
    assign w_d8 = i_lanes[8].value;
    assign w_d9 = i_lanes[9].value;

    assign w_ok_3_5 = i_lanes[3].is_digit & i_lanes[4].is_digit & i_lanes[5].is_digit;
    assign w_ok_3_6 = w_ok_3_5 & i_lanes[6].is_digit;
    assign w_ok_2_9 = w_ok_3_6 & i_lanes[2].is_digit & i_lanes[7].is_digit
                    & i_lanes[8].is_digit & i_lanes[9].is_digit;

    assign w_is_da   = ((i_byte_1 == CH_D) || (i_byte_1 == CH_A)) && (i_byte_10 == CH_SEMI);
    assign w_is_c    = (i_byte_1 == CH_C);
    assign w_cv_form = (i_byte_2 == CH_V) && (i_byte_6 == CH_SEMI);
    assign w_ct_form = (i_byte_2 == CH_T) && (i_byte_7 == CH_SEMI);

    assign w_rate   = 7'(w_d5) * 7'd10 + 7'(w_d6);
    assign w_depth  = 10'(w_d7) * 10'd100 + 10'(w_d8) * 10'd10 + 10'(w_d9);
    assign w_cv_val = 10'(w_d3) * 10'd100 + 10'(w_d4) * 10'd10 + 10'(w_d5);
    assign w_ct_val = 14'(w_d3) * 14'd1000 + 14'(w_d4) * 14'd100
                    + 14'(w_d5) * 14'd10 + 14'(w_d6);

    assign w_count_ok = (w_d4 == 4'd1) || (w_d4 == 4'd2) || (w_d4 == 4'd4) || (w_d4 == 4'd8);

    always_comb begin
        w_err  = ERR_NONE;
        w_next = i_cur;
        // Syntax checks come first; range checks apply only to well-formed commands.
        priority if (w_is_da) begin
            if (!w_ok_2_9) begin
                w_err = ERR_DA_SYNTAX;
            end else if (i_byte_1 == CH_D) begin
                priority if (w_d2 > 4'(TRIG_MAX))             w_err = ERR_D_TRIG;
                else if (w_d3 < LINE_MIN || w_d3 > LINE_MAX)  w_err = ERR_D_LINE;
                else if (!w_count_ok)                         w_err = ERR_D_COUNT;
                else if (w_d3 > w_d4)                         w_err = ERR_D_LINE_COUNT;
                else if (w_rate > D_RATE_MAX)                 w_err = ERR_D_RATE;
                else if (w_depth > DEPTH_MAX)                 w_err = ERR_D_DEPTH;
                else                                          w_err = ERR_NONE;
            end else begin
                priority if (w_d2 > 4'(TRIG_MAX))  w_err = ERR_A_TRIG;
                else if (w_d3 != A_LINE)           w_err = ERR_A_LINE;
                else if (w_d4 != A_COUNT)          w_err = ERR_A_COUNT;
                else if (w_rate > A_RATE_MAX)      w_err = ERR_A_RATE;
                else if (w_depth > DEPTH_MAX)      w_err = ERR_A_DEPTH;
                else                               w_err = ERR_NONE;
            end
            if (w_ok_2_9 && (w_err == ERR_NONE)) begin
                w_next.mode       = (i_byte_1 == CH_D) ? MODE_DIGITAL : MODE_ANALOG;
                w_next.trig_kind  = w_d2[2:0];
                w_next.trig_line  = w_d3;
                w_next.chan_count = w_d4;
                w_next.rate       = w_rate[4:0];
                w_next.depth      = w_depth[7:0];
                w_next.order      = ORDER_SAMPLE;
            end
        end else if (w_is_c) begin
            priority if (w_cv_form) begin
                if (!w_ok_3_5) begin
                    w_err = ERR_CV_SYNTAX;
                end else if (w_cv_val > COMPARE_MAX) begin
                    w_err = ERR_CV_RANGE;
                end else begin
                    w_next.compare = w_cv_val[8:0];
                    w_next.order   = ORDER_VOLTAGE;
                end
            end else if (w_ct_form) begin
                // A four-digit timeout is always in range.
                if (!w_ok_3_6) begin
                    w_err = ERR_CT_SYNTAX;
                end else begin
                    w_next.timeout = w_ct_val;
                    w_next.order   = ORDER_NONE;
                end
            end else begin
                w_err = ERR_C_FORM;
            end
        end else begin
            w_err = ERR_UNKNOWN;
        end
    end

    assign o_verdict.accepted = (w_err == ERR_NONE);
    assign o_verdict.err      = w_err;
    assign o_verdict.next     = w_next;

endmodule

[rtl/core/command_settings_validator.sv]
// Top level of the command settings validator: lanes, merge stage and settings registers.
//
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one ten-byte ASCII command
// per item on i_byte_1 .. i_byte_10. Eight digit lanes decode bytes 2 to 9 in
// parallel and a merge stage derives the error code and the next settings.
// The output channel (o_out_valid / i_out_ready) carries one result per command:
// o_accepted, o_error_code and the stored settings after that command.
// The result is registered: a command accepted at one edge shows its result from the
// next cycle on. Throughput is one command per cycle while the receiver does not stall;
// the settings registers are the only loop and they close through the merge stage.
// o_in_ready is high whenever the output register is empty or being drained, so a
// new command is taken in the same cycle that the previous result leaves.
// When the receiver stalls, the result holds and the input side waits; the stored
// settings change only when a new command is accepted.
// Reset clears all stored settings to zero (digital mode, no pending order) and
// empties the output register.
module command_settings_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic [7:0]  i_byte_8,
    input  logic [7:0]  i_byte_9,
    input  logic [7:0]  i_byte_10,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic [4:0]  o_error_code,
    output logic        o_capture_mode,
    output logic [2:0]  o_trigger_kind,
    output logic [3:0]  o_trigger_line,
    output logic [3:0]  o_channel_count,
    output logic [4:0]  o_rate_code,
    output logic [7:0]  o_depth_kib,
    output logic [8:0]  o_compare_centivolts,
    output logic [13:0] o_timeout_centis,
    output logic [1:0]  o_pending_order
);
    import csv_pkg::*;

    logic [7:0] w_bytes [LANE_HI:LANE_LO];
    t_lanes     w_lanes;
    t_verdict   w_verdict;
    logic       w_in_fire;

    t_settings  r_set;
    logic       r_out_valid;
    logic       r_accepted;
    logic [4:0] r_err;

    assign w_bytes[2] = i_byte_2;
    assign w_bytes[3] = i_byte_3;
    assign w_bytes[4] = i_byte_4;
    assign w_bytes[5] = i_byte_5;
    assign w_bytes[6] = i_byte_6;
    assign w_bytes[7] = i_byte_7;
    assign w_bytes[8] = i_byte_8;
    assign w_bytes[9] = i_byte_9;

    for (genvar g = LANE_LO; g <= LANE_HI; g++) begin : g_lane
        csv_lane u_lane (
            .i_byte (w_bytes[g]),
            .o_lane (w_lanes[g])
        );
    end

    csv_merge u_merge (
        .i_byte_1  (i_byte_1),
        .i_byte_2  (i_byte_2),
        .i_byte_6  (i_byte_6),
        .i_byte_7  (i_byte_7),
        .i_byte_10 (i_byte_10),
        .i_lanes   (w_lanes),
        .i_cur     (r_set),
        .o_verdict (w_verdict)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_set       <= w_verdict.next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_accepted <= w_verdict.accepted;
            r_err      <= w_verdict.err;
        end
    end

    // The settings change only with an accepted command, so they double as payload.
    assign o_out_valid          = r_out_valid;
    assign o_accepted           = r_accepted;
    assign o_error_code         = r_err;
    assign o_capture_mode       = r_set.mode;
    assign o_trigger_kind       = r_set.trig_kind;
    assign o_trigger_line       = r_set.trig_line;
    assign o_channel_count      = r_set.chan_count;
    assign o_rate_code          = r_set.rate;
    assign o_depth_kib          = r_set.depth;
    assign o_compare_centivolts = r_set.compare;
    assign o_timeout_centis     = r_set.timeout;
    assign o_pending_order      = r_set.order;

    a_accept_matches_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_accepted == (r_err == ERR_NONE)))
        else $error("accepted flag disagrees with error code");

    a_err_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_err <= ERR_LAST))
        else $error("error code out of range");

    a_reject_keeps_settings : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_verdict.accepted) |=> $stable(r_set))
        else $error("rejected command changed the settings");

    a_order_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_set.order == ORDER_NONE) || (r_set.order == ORDER_SAMPLE)
        || (r_set.order == ORDER_VOLTAGE))
        else $error("illegal pending order");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_set)))
        else $error("stalled result changed");

endmodule

[tb/command_settings_checker.sv]
// Checker for the command settings validator: predicts each result and compares it.
`timescale 1ns / 100ps

module command_settings_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic [7:0]  i_byte_8,
    input  logic [7:0]  i_byte_9,
    input  logic [7:0]  i_byte_10,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_accepted,
    input  logic [4:0]  i_error_code,
    input  logic        i_capture_mode,
    input  logic [2:0]  i_trigger_kind,
    input  logic [3:0]  i_trigger_line,
    input  logic [3:0]  i_channel_count,
    input  logic [4:0]  i_rate_code,
    input  logic [7:0]  i_depth_kib,
    input  logic [8:0]  i_compare_centivolts,
    input  logic [13:0] i_timeout_centis,
    input  logic [1:0]  i_pending_order,
    output int          o_fail_count,
    output int          o_pending
);
    import csv_pkg::*;

    typedef logic [10:1][7:0] t_command;

    typedef struct packed {
        logic       accepted;
        logic [4:0] err;
        t_settings  s;
    } t_verdict_item;

    t_command      command;
    t_settings     stored_settings;
    t_verdict_item verdict;
    t_verdict_item pending_verdicts[$];
    int            fail_count = 0;
    int            result_idx = 0;

    assign command = {i_byte_10, i_byte_9, i_byte_8, i_byte_7, i_byte_6,
                      i_byte_5, i_byte_4, i_byte_3, i_byte_2, i_byte_1};
    assign o_fail_count = fail_count;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    // Works out the error code and the settings that one command leaves behind.
    function automatic t_verdict_item judge_command(input t_command c, input t_settings cur);
        t_verdict_item res;
        int            d [1:10];
        int            rate;
        int            depth;
        logic [4:0]    err;
        logic          is_da;
        logic          is_cv;
        logic          is_ct;
        res.s = cur;
        for (int i = 1; i <= 10; i++) begin
            d[i] = int'(c[i]) - int'(CH_ZERO);
        end
        is_da = (c[1] == CH_D || c[1] == CH_A) && c[10] == CH_SEMI;
        is_cv = c[1] == CH_C && c[2] == CH_V && c[6] == CH_SEMI;
        is_ct = c[1] == CH_C && !is_cv && c[2] == CH_T && c[7] == CH_SEMI;
        err = ERR_NONE;
        if (is_da) begin
            for (int i = 2; i <= 9; i++) begin
                if (!is_digit(c[i])) err = ERR_DA_SYNTAX;
            end
        end else if (is_cv) begin
            for (int i = 3; i <= 5; i++) begin
                if (!is_digit(c[i])) err = ERR_CV_SYNTAX;
            end
        end else if (is_ct) begin
            for (int i = 3; i <= 6; i++) begin
                if (!is_digit(c[i])) err = ERR_CT_SYNTAX;
            end
        end else if (c[1] == CH_C) begin
            err = ERR_C_FORM;
        end else begin
            err = ERR_UNKNOWN;
        end

        rate  = d[5] * 10 + d[6];
        depth = d[7] * 100 + d[8] * 10 + d[9];
        if (err == ERR_NONE) begin
            if (is_cv) begin
                if (d[3] * 100 + d[4] * 10 + d[5] > COMPARE_MAX) err = ERR_CV_RANGE;
                res.s.compare = 9'(d[3] * 100 + d[4] * 10 + d[5]);
                res.s.order   = ORDER_VOLTAGE;
            end else if (is_ct) begin
                // Four digits never exceed the timeout range, so this form always succeeds.
                res.s.timeout = 14'(d[3] * 1000 + d[4] * 100 + d[5] * 10 + d[6]);
                res.s.order   = ORDER_NONE;
            end else begin
                if (c[1] == CH_D) begin
                    if (d[2] > TRIG_MAX) err = ERR_D_TRIG;
                    else if (d[3] < LINE_MIN || d[3] > LINE_MAX) err = ERR_D_LINE;
                    else if (d[4] != 1 && d[4] != 2 && d[4] != 4 && d[4] != 8)
                        err = ERR_D_COUNT;
                    else if (d[3] > d[4]) err = ERR_D_LINE_COUNT;
                    else if (rate > D_RATE_MAX) err = ERR_D_RATE;
                    else if (depth > DEPTH_MAX) err = ERR_D_DEPTH;
                    res.s.mode = MODE_DIGITAL;
                end else begin
                    if (d[2] > TRIG_MAX) err = ERR_A_TRIG;
                    else if (d[3] != A_LINE) err = ERR_A_LINE;
                    else if (d[4] != A_COUNT) err = ERR_A_COUNT;
                    else if (rate > A_RATE_MAX) err = ERR_A_RATE;
                    else if (depth > DEPTH_MAX) err = ERR_A_DEPTH;
                    res.s.mode = MODE_ANALOG;
                end
                res.s.trig_kind  = 3'(d[2]);
                res.s.trig_line  = 4'(d[3]);
                res.s.chan_count = 4'(d[4]);
                res.s.rate       = 5'(rate);
                res.s.depth      = 8'(depth);
                res.s.order      = ORDER_SAMPLE;
            end
        end
        res.err      = err;
        res.accepted = err == ERR_NONE;
        // A rejected command leaves every stored setting as it was.
        if (!res.accepted) res.s = cur;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [13:0] got,
                               input logic [13:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_idx, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_settings = '0;
            pending_verdicts.delete();
            o_pending <= 0;
        end else begin
            // The result leaving at this edge belongs to an earlier command.
            if (i_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no command waiting",
                                              result_idx));
                end else begin
                    verdict = pending_verdicts.pop_front();
                    check_field("accepted", i_accepted, verdict.accepted);
                    check_field("error_code", i_error_code, verdict.err);
                    check_field("capture_mode", i_capture_mode, verdict.s.mode);
                    check_field("trigger_kind", i_trigger_kind, verdict.s.trig_kind);
                    check_field("trigger_line", i_trigger_line, verdict.s.trig_line);
                    check_field("channel_count", i_channel_count, verdict.s.chan_count);
                    check_field("rate_code", i_rate_code, verdict.s.rate);
                    check_field("depth_kib", i_depth_kib, verdict.s.depth);
                    check_field("compare_centivolts", i_compare_centivolts, verdict.s.compare);
                    check_field("timeout_centis", i_timeout_centis, verdict.s.timeout);
                    check_field("pending_order", i_pending_order, verdict.s.order);
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                verdict = judge_command(command, stored_settings);
                stored_settings = verdict.s;
                pending_verdicts.push_back(verdict);
            end
            o_pending <= pending_verdicts.size();
        end
    end

endmodule

[tb/command_settings_validator_test.sv]
// Top of the command settings validator testbench: clock, reset, commands and verdict.
`timescale 1ns / 100ps

module command_settings_validator_test;
    import csv_pkg::*;

    typedef logic [10:1][7:0] t_command;

    localparam int RANDOM_PER_PHASE = 410;
    localparam int STALL_LIMIT      = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_ready = 1'b0;
    t_command    command = '0;
    logic        in_ready;
    logic        out_valid;
    logic        accepted;
    logic [4:0]  error_code;
    logic        capture_mode;
    logic [2:0]  trigger_kind;
    logic [3:0]  trigger_line;
    logic [3:0]  channel_count;
    logic [4:0]  rate_code;
    logic [7:0]  depth_kib;
    logic [8:0]  compare_centivolts;
    logic [13:0] timeout_centis;
    logic [1:0]  pending_order;
    int          fail_count;
    int          pending;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    command_settings_validator DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_byte_1             (command[1]),
        .i_byte_2             (command[2]),
        .i_byte_3             (command[3]),
        .i_byte_4             (command[4]),
        .i_byte_5             (command[5]),
        .i_byte_6             (command[6]),
        .i_byte_7             (command[7]),
        .i_byte_8             (command[8]),
        .i_byte_9             (command[9]),
        .i_byte_10            (command[10]),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_accepted           (accepted),
        .o_error_code         (error_code),
        .o_capture_mode       (capture_mode),
        .o_trigger_kind       (trigger_kind),
        .o_trigger_line       (trigger_line),
        .o_channel_count      (channel_count),
        .o_rate_code          (rate_code),
        .o_depth_kib          (depth_kib),
        .o_compare_centivolts (compare_centivolts),
        .o_timeout_centis     (timeout_centis),
        .o_pending_order      (pending_order)
    );

    command_settings_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_byte_1             (command[1]),
        .i_byte_2             (command[2]),
        .i_byte_3             (command[3]),
        .i_byte_4             (command[4]),
        .i_byte_5             (command[5]),
        .i_byte_6             (command[6]),
        .i_byte_7             (command[7]),
        .i_byte_8             (command[8]),
        .i_byte_9             (command[9]),
        .i_byte_10            (command[10]),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_accepted           (accepted),
        .i_error_code         (error_code),
        .i_capture_mode       (capture_mode),
        .i_trigger_kind       (trigger_kind),
        .i_trigger_line       (trigger_line),
        .i_channel_count      (channel_count),
        .i_rate_code          (rate_code),
        .i_depth_kib          (depth_kib),
        .i_compare_centivolts (compare_centivolts),
        .i_timeout_centis     (timeout_centis),
        .i_pending_order      (pending_order),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    always @(posedge clk) begin
        out_ready <= $urandom_range(99) >= stall_pct;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] digit_char(input int v);
        return 8'(CH_ZERO + v);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] ch;
        do ch = 8'($urandom_range(255)); while (ch >= CH_ZERO && ch <= CH_NINE);
        return ch;
    endfunction

    // Mostly a value in the legal window, now and then anything the digits allow.
    function automatic int pick(input int lo, input int hi, input int widest);
        if ($urandom_range(7) != 0) return $urandom_range(hi, lo);
        return $urandom_range(widest, 0);
    endfunction

    function automatic t_command da_command(input logic [7:0] letter, input int trig,
                                            input int line, input int count,
                                            input int rate, input int depth);
        t_command c;
        c[1]  = letter;
        c[2]  = digit_char(trig);
        c[3]  = digit_char(line);
        c[4]  = digit_char(count);
        c[5]  = digit_char(rate / 10);
        c[6]  = digit_char(rate % 10);
        c[7]  = digit_char(depth / 100);
        c[8]  = digit_char(depth / 10 % 10);
        c[9]  = digit_char(depth % 10);
        c[10] = CH_SEMI;
        return c;
    endfunction

    function automatic t_command cv_command(input int val);
        t_command c;
        c[1] = CH_C;
        c[2] = CH_V;
        c[3] = digit_char(val / 100);
        c[4] = digit_char(val / 10 % 10);
        c[5] = digit_char(val % 10);
        c[6] = CH_SEMI;
        for (int i = 7; i <= 10; i++) c[i] = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic t_command ct_command(input int val);
        t_command c;
        c[1] = CH_C;
        c[2] = CH_T;
        c[3] = digit_char(val / 1000);
        c[4] = digit_char(val / 100 % 10);
        c[5] = digit_char(val / 10 % 10);
        c[6] = digit_char(val % 10);
        c[7] = CH_SEMI;
        for (int i = 8; i <= 10; i++) c[i] = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic t_command random_command();
        t_command   c;
        int         kind;
        int         count;
        logic [7:0] letter;
        kind   = $urandom_range(99);
        letter = $urandom_range(1) ? CH_D : CH_A;
        count  = ($urandom_range(3) != 0) ? (1 << $urandom_range(3)) : $urandom_range(9);
        if (kind < 30) begin
            c = da_command(CH_D, pick(0, 4, 9), pick(1, count, 9), count,
                           pick(0, 16, 99), pick(0, 192, 999));
        end else if (kind < 52) begin
            c = da_command(CH_A, pick(0, 4, 9), pick(8, 8, 9), pick(1, 1, 9),
                           pick(0, 13, 99), pick(0, 192, 999));
        end else if (kind < 64) begin
            c = cv_command(pick(0, 330, 999));
        end else if (kind < 74) begin
            c = ct_command($urandom_range(9999));
        end else if (kind < 84) begin
            // Terminated D or A command with one position that is not a digit.
            c = da_command(letter, $urandom_range(9), $urandom_range(9), count,
                           $urandom_range(99), $urandom_range(999));
            c[$urandom_range(9, 2)] = non_digit();
        end else if (kind < 90) begin
            c = $urandom_range(1) ? cv_command($urandom_range(999))
                                  : ct_command($urandom_range(9999));
            case ($urandom_range(2))
                0: c[$urandom_range(6, 3)] = non_digit();
                1: c[2] = 8'($urandom_range(255));
                default: c[$urandom_range(7, 6)] = 8'($urandom_range(255));
            endcase
        end else if (kind < 94) begin
            c = da_command(letter, pick(0, 4, 9), pick(1, 8, 9), count,
                           pick(0, 16, 99), pick(0, 192, 999));
            c[10] = 8'($urandom_range(255));
        end else begin
            for (int i = 1; i <= 10; i++) c[i] = 8'($urandom_range(255));
            if ($urandom_range(1)) c[1] = letter;
        end
        return c;
    endfunction

    task automatic send_command(input t_command c);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        do @(posedge clk); while (!in_ready);
    endtask

    // Holds the sender off until every result already owed has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        t_command cmd;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of each field, every accepted form and every error code.
        send_command(da_command(CH_D, 0, 1, 1, 0, 0));
        send_command(da_command(CH_D, 4, 8, 8, 16, 192));
        send_command(da_command(CH_A, 4, 8, 1, 13, 192));
        send_command(cv_command(330));
        send_command(cv_command(0));
        send_command(cv_command(331));
        send_command(ct_command(9999));
        send_command(ct_command(0));
        send_command(da_command(CH_D, 5, 1, 1, 0, 0));
        send_command(da_command(CH_D, 0, 0, 1, 0, 0));
        send_command(da_command(CH_D, 0, 9, 8, 0, 0));
        send_command(da_command(CH_D, 0, 1, 3, 0, 0));
        send_command(da_command(CH_D, 0, 4, 2, 0, 0));
        send_command(da_command(CH_D, 0, 1, 1, 17, 0));
        send_command(da_command(CH_D, 0, 1, 1, 0, 193));
        send_command(da_command(CH_A, 9, 8, 1, 0, 0));
        send_command(da_command(CH_A, 0, 7, 1, 0, 0));
        send_command(da_command(CH_A, 0, 8, 2, 0, 0));
        send_command(da_command(CH_A, 0, 8, 1, 14, 0));
        send_command(da_command(CH_A, 0, 8, 1, 0, 999));
        cmd = da_command(CH_D, 1, 1, 1, 0, 0);
        cmd[5] = "x";
        send_command(cmd);
        cmd = cv_command(100);
        cmd[4] = "/";
        send_command(cmd);
        cmd = ct_command(1234);
        cmd[6] = ":";
        send_command(cmd);
        cmd = cv_command(5);
        cmd[2] = "X";
        send_command(cmd);
        cmd = da_command(CH_A, 0, 8, 1, 0, 0);
        cmd[10] = 8'h00;
        send_command(cmd);
        cmd[1] = "Z";
        send_command(cmd);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            repeat (RANDOM_PER_PHASE) send_command(random_command());
            drain_results();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
